@@ hdl/pbd_pkg.sv @@
`default_nettype none
package pbd_pkg;

   localparam int POS_W      = 24;
   localparam int STIFF_W    = 17;
   localparam int ROOT_STEPS = 25;
   localparam int DIR_STEPS  = 29;

   typedef struct packed {
      logic signed [23:0] x1;
      logic signed [23:0] y1;
      logic signed [23:0] x2;
      logic signed [23:0] y2;
      logic [23:0]        rest;
      logic [16:0]        stiff;
      logic               dxn;
      logic               dyn;
      logic [24:0]        adx;
      logic [24:0]        ady;
      logic [24:0]        wsum;
      logic [49:0]        rad;
      logic [24:0]        root;
      logic [47:0]        rm1;
      logic [47:0]        rm2;
      logic [24:0]        q1;
      logic [24:0]        q2;
      logic               skip;
      logic signed [43:0] prod;
      logic [52:0]        rmx;
      logic [52:0]        rmy;
      logic [28:0]        qx;
      logic [28:0]        qy;
      logic signed [52:0] kp1;
      logic signed [52:0] kp2;
      logic signed [56:0] m1x;
      logic signed [56:0] m1y;
      logic signed [56:0] m2x;
      logic signed [56:0] m2y;
      logic               applied;
   } item_type;

   // divide by 2^16, rounding toward zero
   function automatic logic signed [26:0] trunc_k(input logic signed [43:0] v);
      logic signed [43:0] a;
      a = v[43] ? v + 44'sd65535 : v;
      return a[42:16];
   endfunction

   // divide by 2^24, rounding toward zero
   function automatic logic signed [26:0] trunc_r(input logic signed [52:0] v);
      logic signed [52:0] a;
      a = v[52] ? v + 53'sd16777215 : v;
      return a[50:24];
   endfunction

   // divide by 2^28, rounding toward zero
   function automatic logic signed [26:0] trunc_d(input logic signed [56:0] v);
      logic signed [56:0] a;
      a = v[56] ? v + 57'sd268435455 : v;
      return a[54:28];
   endfunction

   function automatic logic [23:0] sat_pos(input logic signed [27:0] v);
      logic [23:0] r;
      if (v > 28'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (v < -28'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hdl/pbd_root_cell.sv @@
`default_nettype none
// one result bit of the distance root and of both mass ratios
module pbd_root_cell import pbd_pkg::*; #(
   parameter int BIT = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     up_vld,
   input  wire item_type up_itm,
   output logic          dn_vld,
   output item_type      dn_itm
);

   logic     vld_ff;
   item_type itm_ff;
   item_type itm_in;
   logic [50:0] trial;
   logic [48:0] dv1;
   logic [48:0] dv2;

   always_comb begin
      itm_in = up_itm;
      trial  = ({26'b0, up_itm.root} << (BIT + 1)) | (51'(1) << (2 * BIT));
      dv1    = {24'b0, up_itm.wsum} << BIT;
      dv2    = dv1;
      if ({1'b0, up_itm.rad} >= trial) begin
         itm_in.rad       = 50'({1'b0, up_itm.rad} - trial);
         itm_in.root[BIT] = 1'b1;
      end
      if ({1'b0, up_itm.rm1} >= dv1) begin
         itm_in.rm1     = 48'({1'b0, up_itm.rm1} - dv1);
         itm_in.q1[BIT] = 1'b1;
      end
      if ({1'b0, up_itm.rm2} >= dv2) begin
         itm_in.rm2     = 48'({1'b0, up_itm.rm2} - dv2);
         itm_in.q2[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         itm_ff <= itm_in;
      end
   end

   assign dn_vld = vld_ff;
   assign dn_itm = itm_ff;

endmodule
`default_nettype wire

@@ hdl/pbd_dir_cell.sv @@
`default_nettype none
// one result bit of both direction quotients
module pbd_dir_cell import pbd_pkg::*; #(
   parameter int BIT = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     up_vld,
   input  wire item_type up_itm,
   output logic          dn_vld,
   output item_type      dn_itm
);

   logic     vld_ff;
   item_type itm_ff;
   item_type itm_in;
   logic [52:0] dv;

   always_comb begin
      itm_in = up_itm;
      dv     = {28'b0, up_itm.root} << BIT;
      if (up_itm.rmx >= dv) begin
         itm_in.rmx     = up_itm.rmx - dv;
         itm_in.qx[BIT] = 1'b1;
      end
      if (up_itm.rmy >= dv) begin
         itm_in.rmy     = up_itm.rmy - dv;
         itm_in.qy[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         itm_ff <= itm_in;
      end
   end

   assign dn_vld = vld_ff;
   assign dn_itm = itm_ff;

endmodule
`default_nettype wire

@@ hdl/pbd_distance_constraint_projector.sv @@
// Distance constraint projector, one constraint per item.
// req_ channel: positions, inverse masses, rest length and stiffness of one
// constraint. rsp_ channel: the four corrected positions and the applied flag.
// An item is taken on a clock edge with valid high and stall low.
// The stages are the input stage, square stage, 25 root/ratio cells
// (one bit of the root and of both mass ratios per cell), error stage,
// 29 direction cells (one quotient bit each), two multiply stages and the
// output register. Throughput is one item per cycle while rsp_stall is low.
// Each stage holds one item and moves it on when the next stage is empty or
// moving, so a stalled receiver only backs up the pipeline once every stage
// is full; req_stall rises then. Stalled outputs hold steady.
// Coincident particles or two immovable particles give the positions back
// unchanged with rsp_applied low. Results saturate to the position range.
// Synchronous reset empties every stage; items in flight are dropped.
`default_nettype none
module pbd_distance_constraint_projector import pbd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [POS_W-1:0]     req_first_x,
   input  wire logic [POS_W-1:0]     req_first_y,
   input  wire logic [POS_W-1:0]     req_first_inv_mass,
   input  wire logic [POS_W-1:0]     req_second_x,
   input  wire logic [POS_W-1:0]     req_second_y,
   input  wire logic [POS_W-1:0]     req_second_inv_mass,
   input  wire logic [POS_W-1:0]     req_rest_length,
   input  wire logic [STIFF_W-1:0]   req_stiffness,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [POS_W-1:0]          rsp_new_first_x,
   output logic [POS_W-1:0]          rsp_new_first_y,
   output logic [POS_W-1:0]          rsp_new_second_x,
   output logic [POS_W-1:0]          rsp_new_second_y,
   output logic                      rsp_applied
);

   localparam int S_ROOT = 2;
   localparam int S_ERR  = S_ROOT + ROOT_STEPS;
   localparam int S_DIR  = S_ERR + 1;
   localparam int S_K    = S_DIR + DIR_STEPS;
   localparam int S_M    = S_K + 1;
   localparam int S_OUT  = S_M + 1;
   localparam int N_STG  = S_OUT + 1;

   logic     vld [N_STG];
   item_type itm [N_STG];
   logic     rdy [N_STG + 1];

   assign rdy[N_STG] = !rsp_stall;
   for (genvar i = 0; i < N_STG; i++) begin : g_rdy
      assign rdy[i] = !vld[i] || rdy[i + 1];
   end

   assign req_stall = !rdy[0];

   // input stage
   logic        s0_vld_ff;
   item_type    s0_itm_ff;
   item_type    s0_itm_in;
   logic signed [24:0] dx;
   logic signed [24:0] dy;

   always_comb begin
      s0_itm_in      = '0;
      dx             = $signed({req_second_x[23], req_second_x})
                     - $signed({req_first_x[23], req_first_x});
      dy             = $signed({req_second_y[23], req_second_y})
                     - $signed({req_first_y[23], req_first_y});
      s0_itm_in.x1   = req_first_x;
      s0_itm_in.y1   = req_first_y;
      s0_itm_in.x2   = req_second_x;
      s0_itm_in.y2   = req_second_y;
      s0_itm_in.rest = req_rest_length;
      s0_itm_in.stiff = req_stiffness;
      s0_itm_in.dxn  = dx[24];
      s0_itm_in.dyn  = dy[24];
      s0_itm_in.adx  = dx[24] ? 25'(-dx) : 25'(dx);
      s0_itm_in.ady  = dy[24] ? 25'(-dy) : 25'(dy);
      s0_itm_in.wsum = {1'b0, req_first_inv_mass} + {1'b0, req_second_inv_mass};
      s0_itm_in.rm1  = {req_first_inv_mass, 24'b0};
      s0_itm_in.rm2  = {req_second_inv_mass, 24'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (rdy[0]) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_itm_ff <= s0_itm_in;
      end
   end

   assign vld[0] = s0_vld_ff;
   assign itm[0] = s0_itm_ff;

   // squared distance
   logic        s1_vld_ff;
   item_type    s1_itm_ff;
   item_type    s1_itm_in;
   logic [49:0] sqx;
   logic [49:0] sqy;

   always_comb begin
      sqx            = itm[0].adx * itm[0].adx;
      sqy            = itm[0].ady * itm[0].ady;
      s1_itm_in      = itm[0];
      s1_itm_in.rad  = sqx + sqy;
      s1_itm_in.root = '0;
      s1_itm_in.q1   = '0;
      s1_itm_in.q2   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (rdy[1]) begin
         s1_vld_ff <= vld[0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_itm_ff <= s1_itm_in;
      end
   end

   assign vld[1] = s1_vld_ff;
   assign itm[1] = s1_itm_ff;

   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
      pbd_root_cell #(
         .BIT(ROOT_STEPS - 1 - i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (rdy[S_ROOT + i]),
         .up_vld (vld[S_ROOT + i - 1]),
         .up_itm (itm[S_ROOT + i - 1]),
         .dn_vld (vld[S_ROOT + i]),
         .dn_itm (itm[S_ROOT + i])
      );
   end

   // length error times stiffness
   logic               se_vld_ff;
   item_type           se_itm_ff;
   item_type           se_itm_in;
   logic signed [25:0] err;

   always_comb begin
      se_itm_in      = itm[S_ERR - 1];
      err            = $signed({1'b0, se_itm_in.root}) - $signed({2'b0, se_itm_in.rest});
      se_itm_in.prod = err * $signed({1'b0, se_itm_in.stiff});
      se_itm_in.skip = (se_itm_in.root == '0) || (se_itm_in.wsum == '0);
      se_itm_in.rmx  = {se_itm_in.adx, 28'b0};
      se_itm_in.rmy  = {se_itm_in.ady, 28'b0};
      se_itm_in.qx   = '0;
      se_itm_in.qy   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         se_vld_ff <= 1'b0;
      end else if (rdy[S_ERR]) begin
         se_vld_ff <= vld[S_ERR - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_ERR]) begin
         se_itm_ff <= se_itm_in;
      end
   end

   assign vld[S_ERR] = se_vld_ff;
   assign itm[S_ERR] = se_itm_ff;

   for (genvar i = 0; i < DIR_STEPS; i++) begin : g_dir
      pbd_dir_cell #(
         .BIT(DIR_STEPS - 1 - i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (rdy[S_DIR + i]),
         .up_vld (vld[S_DIR + i - 1]),
         .up_itm (itm[S_DIR + i - 1]),
         .dn_vld (vld[S_DIR + i]),
         .dn_itm (itm[S_DIR + i])
      );
   end

   // share of the correction per particle
   logic               sk_vld_ff;
   item_type           sk_itm_ff;
   item_type           sk_itm_in;
   logic signed [26:0] k;

   always_comb begin
      sk_itm_in     = itm[S_K - 1];
      k             = trunc_k(sk_itm_in.prod);
      sk_itm_in.kp1 = k * $signed({1'b0, sk_itm_in.q1});
      sk_itm_in.kp2 = k * $signed({1'b0, sk_itm_in.q2});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_vld_ff <= 1'b0;
      end else if (rdy[S_K]) begin
         sk_vld_ff <= vld[S_K - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_K]) begin
         sk_itm_ff <= sk_itm_in;
      end
   end

   assign vld[S_K] = sk_vld_ff;
   assign itm[S_K] = sk_itm_ff;

   // moves along the direction
   logic               sm_vld_ff;
   item_type           sm_itm_ff;
   item_type           sm_itm_in;
   logic signed [26:0] k1;
   logic signed [26:0] k2;
   logic signed [29:0] ux;
   logic signed [29:0] uy;

   always_comb begin
      sm_itm_in     = itm[S_M - 1];
      k1            = trunc_r(sm_itm_in.kp1);
      k2            = trunc_r(sm_itm_in.kp2);
      ux            = sm_itm_in.dxn ? -$signed({1'b0, sm_itm_in.qx})
                                    :  $signed({1'b0, sm_itm_in.qx});
      uy            = sm_itm_in.dyn ? -$signed({1'b0, sm_itm_in.qy})
                                    :  $signed({1'b0, sm_itm_in.qy});
      sm_itm_in.m1x = k1 * ux;
      sm_itm_in.m1y = k1 * uy;
      sm_itm_in.m2x = k2 * ux;
      sm_itm_in.m2y = k2 * uy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else if (rdy[S_M]) begin
         sm_vld_ff <= vld[S_M - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_M]) begin
         sm_itm_ff <= sm_itm_in;
      end
   end

   assign vld[S_M] = sm_vld_ff;
   assign itm[S_M] = sm_itm_ff;

   // output register
   logic     so_vld_ff;
   item_type so_itm_ff;
   item_type so_itm_in;

   always_comb begin
      so_itm_in         = itm[S_OUT - 1];
      so_itm_in.applied = 1'b0;
      if (!so_itm_in.skip) begin
         so_itm_in.x1      = sat_pos(28'(itm[S_OUT - 1].x1) + 28'(trunc_d(itm[S_OUT - 1].m1x)));
         so_itm_in.y1      = sat_pos(28'(itm[S_OUT - 1].y1) + 28'(trunc_d(itm[S_OUT - 1].m1y)));
         so_itm_in.x2      = sat_pos(28'(itm[S_OUT - 1].x2) - 28'(trunc_d(itm[S_OUT - 1].m2x)));
         so_itm_in.y2      = sat_pos(28'(itm[S_OUT - 1].y2) - 28'(trunc_d(itm[S_OUT - 1].m2y)));
         so_itm_in.applied = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         so_vld_ff <= 1'b0;
      end else if (rdy[S_OUT]) begin
         so_vld_ff <= vld[S_OUT - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_OUT]) begin
         so_itm_ff <= so_itm_in;
      end
   end

   assign vld[S_OUT] = so_vld_ff;
   assign itm[S_OUT] = so_itm_ff;

   assign rsp_valid        = vld[S_OUT];
   assign rsp_new_first_x  = itm[S_OUT].x1;
   assign rsp_new_first_y  = itm[S_OUT].y1;
   assign rsp_new_second_x = itm[S_OUT].x2;
   assign rsp_new_second_y = itm[S_OUT].y2;
   assign rsp_applied      = itm[S_OUT].applied;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
   import pbd_pkg::*;

   typedef struct {
      logic [23:0] first_x, first_y, first_inv_mass;
      logic [23:0] second_x, second_y, second_inv_mass;
      logic [23:0] rest_length;
      logic [16:0] stiffness;
   } constraint_type;

   typedef struct {
      logic [23:0] first_x, first_y, second_x, second_y;
      logic        applied;
   } projection_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_first_x = '0, req_first_y = '0, req_first_inv_mass = '0;
   logic [23:0] req_second_x = '0, req_second_y = '0, req_second_inv_mass = '0;
   logic [23:0] req_rest_length = '0;
   logic [16:0] req_stiffness = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [23:0] rsp_new_first_x, rsp_new_first_y, rsp_new_second_x, rsp_new_second_y;
   logic        rsp_applied;

   constraint_type pending_items[$];
   projection_type expected_positions[$];
   int          accepted = 0;
   int          errors = 0;
   int          idle_cycles = 0;
   int          hold_left = 0;
   bit          hold_done = 0;

   always #2 clock = ~clock;

   pbd_distance_constraint_projector u_top (.*);

   function automatic void add_pending(constraint_type c);
      pending_items.insert(pending_items.size(), c);
   endfunction

   function automatic logic [23:0] clamp_pos(longint v);
      if (v > 64'sd8388607) return 24'h7FFFFF;
      if (v < -64'sd8388608) return 24'h800000;
      return v[23:0];
   endfunction

   function automatic projection_type project(constraint_type c);
      projection_type p;
      longint x1, y1, x2, y2, w1, w2, wsum, dx, dy, d, cand, err, k, r1, r2, k1, k2, ux, uy;
      longint unsigned sq;
      x1 = longint'($signed(c.first_x));
      y1 = longint'($signed(c.first_y));
      x2 = longint'($signed(c.second_x));
      y2 = longint'($signed(c.second_y));
      w1 = longint'(c.first_inv_mass);
      w2 = longint'(c.second_inv_mass);
      wsum = w1 + w2;
      dx = x2 - x1;
      dy = y2 - y1;
      sq = dx * dx + dy * dy;
      d = 0;
      for (int b = 25; b >= 0; b--) begin
         cand = d | (64'sd1 << b);
         if (longint'(cand * cand) <= sq) d = cand;
      end
      p.first_x = c.first_x;
      p.first_y = c.first_y;
      p.second_x = c.second_x;
      p.second_y = c.second_y;
      p.applied = 1'b0;
      if (d == 0 || wsum == 0) return p;
      err = d - longint'(c.rest_length);
      k = (err * longint'(c.stiffness)) / (64'sd1 <<< 16);
      r1 = (w1 <<< 24) / wsum;
      r2 = (w2 <<< 24) / wsum;
      k1 = (k * r1) / (64'sd1 <<< 24);
      k2 = (k * r2) / (64'sd1 <<< 24);
      ux = (dx <<< 28) / d;
      uy = (dy <<< 28) / d;
      p.first_x = clamp_pos(x1 + (k1 * ux) / (64'sd1 <<< 28));
      p.first_y = clamp_pos(y1 + (k1 * uy) / (64'sd1 <<< 28));
      p.second_x = clamp_pos(x2 - (k2 * ux) / (64'sd1 <<< 28));
      p.second_y = clamp_pos(y2 - (k2 * uy) / (64'sd1 <<< 28));
      p.applied = 1'b1;
      return p;
   endfunction

   function automatic logic [23:0] rand24();
      return 24'($urandom());
   endfunction

   function automatic constraint_type random_constraint();
      constraint_type c;
      c.first_x = rand24();
      c.first_y = rand24();
      c.first_inv_mass = rand24();
      c.second_x = rand24();
      c.second_y = rand24();
      c.second_inv_mass = rand24();
      c.rest_length = rand24();
      c.stiffness = 17'($urandom_range(0, 131071));
      if ($urandom_range(0, 2) != 0) begin
         // nearby particles with a plausible rest length
         c.second_x = c.first_x + 24'($signed($urandom_range(0, 2000000)) - 1000000);
         c.second_y = c.first_y + 24'($signed($urandom_range(0, 2000000)) - 1000000);
         c.rest_length = 24'($urandom_range(0, 1500000));
         c.stiffness = 17'($urandom_range(0, 65536));
         c.first_inv_mass = 24'($urandom_range(0, 200000));
         c.second_inv_mass = 24'($urandom_range(0, 200000));
      end
      case ($urandom_range(0, 11))
         0: c.first_inv_mass = '0;
         1: c.second_inv_mass = '0;
         2: begin
            c.first_inv_mass = '0;
            c.second_inv_mass = '0;
         end
         3: begin
            c.second_x = c.first_x;
            c.second_y = c.first_y;
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic constraint_type make_constraint(logic [23:0] x1, y1, w1, x2, y2, w2, rl,
                                                      logic [16:0] st);
      constraint_type c;
      c.first_x = x1;
      c.first_y = y1;
      c.first_inv_mass = w1;
      c.second_x = x2;
      c.second_y = y2;
      c.second_inv_mass = w2;
      c.rest_length = rl;
      c.stiffness = st;
      return c;
   endfunction

   function automatic bit sender_idles();
      if (accepted < 320) return $urandom_range(0, 99) < 19;
      if (accepted < 640) return $urandom_range(0, 99) < 73;
      return 1'b0;
   endfunction

   function automatic bit receiver_idles();
      if (accepted < 320) return $urandom_range(0, 99) < 73;
      if (accepted < 640) return $urandom_range(0, 99) < 19;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      constraint_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            c.first_x = req_first_x;
            c.first_y = req_first_y;
            c.first_inv_mass = req_first_inv_mass;
            c.second_x = req_second_x;
            c.second_y = req_second_y;
            c.second_inv_mass = req_second_inv_mass;
            c.rest_length = req_rest_length;
            c.stiffness = req_stiffness;
            expected_positions.insert(expected_positions.size(), project(c));
            accepted <= accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && !sender_idles()) begin
               c = pending_items.pop_front();
               req_first_x <= c.first_x;
               req_first_y <= c.first_y;
               req_first_inv_mass <= c.first_inv_mass;
               req_second_x <= c.second_x;
               req_second_y <= c.second_y;
               req_second_inv_mass <= c.second_inv_mass;
               req_rest_length <= c.rest_length;
               req_stiffness <= c.stiffness;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      projection_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               $error("unexpected result");
               errors++;
            end else begin
               e = expected_positions.pop_front();
               if (rsp_new_first_x !== e.first_x) begin
                  $error("new_first_x exp %h got %h", e.first_x, rsp_new_first_x);
                  errors++;
               end
               if (rsp_new_first_y !== e.first_y) begin
                  $error("new_first_y exp %h got %h", e.first_y, rsp_new_first_y);
                  errors++;
               end
               if (rsp_new_second_x !== e.second_x) begin
                  $error("new_second_x exp %h got %h", e.second_x, rsp_new_second_x);
                  errors++;
               end
               if (rsp_new_second_y !== e.second_y) begin
                  $error("new_second_y exp %h got %h", e.second_y, rsp_new_second_y);
                  errors++;
               end
               if (rsp_applied !== e.applied) begin
                  $error("applied exp %b got %b", e.applied, rsp_applied);
                  errors++;
               end
            end
         end
         if (!hold_done && accepted >= 700) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_idles();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 3000) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      add_pending(make_constraint(0, 0, 65536, 65536, 0, 65536, 32768, 65536));
      add_pending(make_constraint(0, 0, 65536, 0, 0, 65536, 0, 65536));
      add_pending(make_constraint(100, 200, 0, 900, 700, 0, 10, 65536));
      add_pending(make_constraint(24'h800000, 24'h800000, 24'hFFFFFF,
                                  24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF,
                                  0, 17'h1FFFF));
      add_pending(make_constraint(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF,
                                  24'h800000, 24'h800000, 0,
                                  0, 17'h1FFFF));
      add_pending(make_constraint(24'h7FFFFF, 0, 65536, 24'h7FFF00, 0, 65536,
                                  24'hFFFFFF, 17'h1FFFF));
      add_pending(make_constraint(24'h800000, 0, 1, 24'h800100, 0, 0,
                                  24'hFFFFFF, 65536));
      add_pending(make_constraint(0, 0, 65536, 300000, -24'sd400000, 131072,
                                  100000, 0));
      add_pending(make_constraint(0, 0, 1, 1, 1, 1, 0, 98304));
      add_pending(make_constraint(5000, -24'sd5000, 24'hFFFFFF, -24'sd5000,
                                  5000, 1, 24'hFFFFFF, 32768));
      add_pending(make_constraint(24'h7FFFFF, 24'h800000, 0, 24'h7FFFFF,
                                  24'h800000, 0, 24'hFFFFFF, 17'h1FFFF));
      add_pending(make_constraint(1000, 1000, 65536, 1000, 70000, 0,
                                  65536, 65536));
      for (int i = 0; i < 950; i++) add_pending(random_constraint());
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_positions.size() != 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_positions.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
